// ----- design/ntc_thermistor_temperature_assert.svh -----
// ----------------------------------------------------------------------------
// ntc thermistor temperature assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef NTC_THERMISTOR_TEMPERATURE_ASSERT_SVH
`define NTC_THERMISTOR_TEMPERATURE_ASSERT_SVH

// same-cycle implication
`define NTC_ASSERT_IMPLY(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NTC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntc_pkg
// shared widths, codes, command and status types and the log table builder
// ----------------------------------------------------------------------------
`default_nettype none

package ntc_pkg;

	localparam int SampleW  = 10;
	localparam int ChanW    = 2;
	localparam int TempW    = 15;
	localparam int StatW    = 2;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 20;
	localparam int SumW     = 18;
	localparam int CntW     = 8;
	localparam int ResW     = 20;
	localparam int BetaW    = 14;
	localparam int TcW      = 15;
	localparam int AvgW     = 26;
	localparam int ExpW     = 5;
	localparam int LnW      = 21;
	localparam int LaccW    = 24;
	localparam int DivNW    = 59;
	localparam int DivDW    = 38;

	localparam int DefAdcFullScale = 1023;
	localparam int DefLnTableDepth = 64;

	localparam logic [15:0] Ln2Q16    = 16'd45426;
	localparam logic [16:0] ZeroCenti = 17'd27315;
	localparam logic [22:0] BetaScale = 23'd6553600;
	localparam logic [28:0] NumScale  = 29'd419430400;
	localparam logic [23:0] RecipM    = 24'd10737419;
	localparam logic [22:0] RoundOfs  = 23'd90;
	localparam logic signed [17:0] TempBias = 18'sd17482;
	localparam logic signed [17:0] RMax     = 18'sd16383;
	localparam logic signed [17:0] RMin     = -18'sd16384;

	localparam logic [TempW-1:0] TempMax = 15'h3fff;
	localparam logic [TempW-1:0] TempMin = 15'h4000;

	localparam logic [CfgIdxW-1:0] RegSampleCount = 3'd0;
	localparam logic [CfgIdxW-1:0] RegSeriesRes   = 3'd1;
	localparam logic [CfgIdxW-1:0] RegNominalRes  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegBeta        = 3'd3;
	localparam logic [CfgIdxW-1:0] RegNominalTemp = 3'd4;

	localparam logic [StatW-1:0] StOk      = 2'd0;
	localparam logic [StatW-1:0] StAvgZero = 2'd1;
	localparam logic [StatW-1:0] StAvgFull = 2'd2;
	localparam logic [StatW-1:0] StSat     = 2'd3;

	localparam logic [1:0] LnSelRs   = 2'd0;
	localparam logic [1:0] LnSelAvg  = 2'd1;
	localparam logic [1:0] LnSelDiff = 2'd2;
	localparam logic [1:0] LnSelR0   = 2'd3;

	typedef struct packed {
		logic       acc;
		logic       div_avg;
		logic       take_avg;
		logic       ln_start;
		logic [1:0] ln_sel;
		logic       mul1;
		logic       mul2;
		logic       add;
		logic       div_temp;
		logic       recip;
		logic       fin;
		logic       load_out;
	} ntc_cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
		logic avg_bad;
		logic ln_done;
		logic den_pos;
		logic out_busy;
	} ntc_stat_t;

	// elaboration-time restoring divide for the table builder
	function automatic logic [63:0] ntc_udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = n;
		for (int i = 0; i < 64; i++) begin
			r = {r[63:0], q[63]};
			q = {q[62:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// ln(1 + k/d) in q16 via the atanh series
	function automatic logic [15:0] ntc_ln_entry(input int k, input int d);
		logic [63:0] kk;
		logic [63:0] dd;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] tot;
		kk = 64'(k);
		dd = 64'(d);
		z = ntc_udiv64(kk << 32, 64'd2 * dd + kk);
		z2 = (z * z) >> 32;
		term = z;
		s = '0;
		for (int n = 0; n < 25; n++) begin
			s = s + ntc_udiv64(term, 64'(2 * n + 1));
			term = (term * z2) >> 32;
		end
		tot = (64'd2 * s + 64'd32768) >> 16;
		return tot[15:0];
	endfunction

endpackage

`default_nettype wire

// ----- design/ntc_div.sv -----
// ----------------------------------------------------------------------------
// ntc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ntc_pkg::DivNW-1:0] num,
	input  wire logic [ntc_pkg::DivDW-1:0] den,
	output logic                           done,
	output logic [ntc_pkg::DivNW-1:0]      quo
);
	import ntc_pkg::*;

	localparam int CW = $clog2(DivNW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DivDW-1:0]  den_q;
	logic [DivDW:0]    rem_q;
	logic [DivNW-1:0]  quo_q;
	logic [DivDW:0]    rem_sh;
	logic [DivDW:0]    rem_nx;
	logic              fits;

	always_comb begin
		rem_sh = {rem_q[DivDW-1:0], quo_q[DivNW-1]};
		fits = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DivNW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DivNW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

`default_nettype wire

// ----- design/ntc_ln.sv -----
// ----------------------------------------------------------------------------
// ntc_ln
// natural log in q16: normalize, table lookup, linear interpolation
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_ln #(
	parameter int LnDepth = ntc_pkg::DefLnTableDepth
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [ntc_pkg::AvgW-1:0] x,
	output logic                          done,
	output logic [ntc_pkg::LnW-1:0]       res
);
	import ntc_pkg::*;

	localparam int IW = $clog2(LnDepth);
	localparam int DW = $clog2(LnDepth + 1);
	localparam int FracPad = 33 - AvgW;
	localparam logic [DW-1:0] DepthC = DW'(LnDepth);

	localparam logic [2:0] LnIdle = 3'd0;
	localparam logic [2:0] LnNorm = 3'd1;
	localparam logic [2:0] LnMul  = 3'd2;
	localparam logic [2:0] LnLook = 3'd3;
	localparam logic [2:0] LnSum  = 3'd4;

	logic [2:0]        state_q;
	logic              done_q;
	logic [AvgW-1:0]   x_q;
	logic [ExpW-1:0]   e_q;
	logic [31+DW:0]    pos_s1;
	logic [15:0]       lo_s2;
	logic [47:0]       dm_s2;
	logic [LnW-1:0]    res_q;
	logic [31:0]       frac;
	logic [IW-1:0]     idx;
	logic [15:0]       lo;
	logic [15:0]       hi;
	logic [15:0]       ln_tab [LnDepth+1];

	for (genvar k = 0; k <= LnDepth; k++) begin : g_tab
		localparam logic [15:0] Ent = ntc_ln_entry(k, LnDepth);
		assign ln_tab[k] = Ent;
	end

	assign frac = {x_q[AvgW-2:0], {FracPad{1'b0}}};
	assign idx = pos_s1[32 +: IW];
	assign lo = ln_tab[DW'(idx)];
	assign hi = ln_tab[DW'(idx) + DW'(1)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LnIdle;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				LnIdle: begin
					if (start) state_q <= LnNorm;
				end
				LnNorm: begin
					if (x_q[AvgW-1]) state_q <= LnMul;
				end
				LnMul: state_q <= LnLook;
				LnLook: state_q <= LnSum;
				LnSum: begin
					done_q <= 1'b1;
					state_q <= LnIdle;
				end
				default: state_q <= LnIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LnIdle: begin
				if (start) begin
					x_q <= (x == '0) ? AvgW'(1) : x;
					e_q <= ExpW'(AvgW - 1);
				end
			end
			LnNorm: begin
				if (!x_q[AvgW-1]) begin
					x_q <= x_q << 1;
					e_q <= e_q - ExpW'(1);
				end
			end
			LnMul: pos_s1 <= (32+DW)'(frac) * (32+DW)'(DepthC);
			LnLook: begin
				lo_s2 <= lo;
				dm_s2 <= 48'(hi - lo) * 48'(pos_s1[31:0]);
			end
			LnSum: res_q <= LnW'(e_q) * LnW'(Ln2Q16) + LnW'(lo_s2) + LnW'(dm_s2[47:32]);
			default: ;
		endcase
	end

	assign done = done_q;
	assign res = res_q;

endmodule

`default_nettype wire

// ----- design/ntc_dp.sv -----
// ----------------------------------------------------------------------------
// ntc_dp
// accumulator, config registers, shared divider, log unit and result math
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_dp #(
	parameter int AdcFullScale = ntc_pkg::DefAdcFullScale,
	parameter int LnDepth      = ntc_pkg::DefLnTableDepth
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ntc_pkg::ntc_cmd_t            cmd,
	output ntc_pkg::ntc_stat_t                stat,
	input  wire logic [ntc_pkg::SampleW-1:0]  sample,
	input  wire logic [ntc_pkg::ChanW-1:0]    chan,
	input  wire logic                         cfg_we,
	input  wire logic [ntc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [ntc_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [ntc_pkg::TempW-1:0]         out_temp,
	output logic [ntc_pkg::ChanW-1:0]         out_chan,
	output logic [ntc_pkg::StatW-1:0]         out_status
);
	import ntc_pkg::*;

	localparam logic [DivNW-1:0] FullQ8 = DivNW'(AdcFullScale * 256);

	logic [CntW-1:0]  sc_q;
	logic [ResW-1:0]  rs_q;
	logic [ResW-1:0]  r0_q;
	logic [BetaW-1:0] beta_q;
	logic [TcW-1:0]   tc_q;
	logic [SumW-1:0]  sum_q;
	logic [CntW-1:0]  seen_q;
	logic [ChanW-1:0] chan_q;
	logic [CntW-1:0]  need;
	logic [CntW-1:0]  seen_nx;

	logic             div_start;
	logic [DivNW-1:0] div_num;
	logic [DivDW-1:0] div_den;
	logic             div_done;
	logic [DivNW-1:0] quo;

	logic [AvgW-1:0]  avg_q;
	logic             zero_q;
	logic             full_q;
	logic [AvgW-1:0]  ln_x;
	logic             ln_done;
	logic [LnW-1:0]   ln_res;
	logic signed [LaccW-1:0] lacc_q;

	logic [16:0]      t0;
	logic [15:0]      t0u;
	logic [BetaW-1:0] beff;
	logic signed [41:0] lt_s1;
	logic [29:0]      bt_s1;
	logic [36:0]      bc_s1;
	logic signed [41:0] den_q;
	logic [DivNW-1:0] numa_s2;
	logic [DivNW-1:0] num_q;
	logic             den_pos;
	logic             sathi_q;
	logic [22:0]      u;
	logic [46:0]      rp_s1;
	logic signed [17:0] rr;
	logic [TempW-1:0] res_temp_q;
	logic [StatW-1:0] res_stat_q;
	logic             out_valid_q;
	logic [TempW-1:0] out_temp_q;
	logic [ChanW-1:0] out_chan_q;
	logic [StatW-1:0] out_stat_q;

	assign need = (sc_q == '0) ? CntW'(1) : sc_q;
	assign seen_nx = seen_q + CntW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= CntW'(5);
			rs_q <= ResW'(10000);
			r0_q <= ResW'(10000);
			beta_q <= BetaW'(3950);
			tc_q <= TcW'(2500);
			sum_q <= '0;
			seen_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegSampleCount: sc_q <= cfg_data[CntW-1:0];
					RegSeriesRes:   rs_q <= cfg_data[ResW-1:0];
					RegNominalRes:  r0_q <= cfg_data[ResW-1:0];
					RegBeta:        beta_q <= cfg_data[BetaW-1:0];
					RegNominalTemp: tc_q <= cfg_data[TcW-1:0];
					default: ;
				endcase
			end
			if (cmd.acc) begin
				sum_q <= sum_q + SumW'(sample);
				seen_q <= seen_nx;
			end else if (cmd.div_avg) begin
				sum_q <= '0;
				seen_q <= '0;
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// shared divider: average first, then the temperature quotient
	assign div_start = cmd.div_avg | cmd.div_temp;
	assign div_num = cmd.div_avg ? DivNW'({sum_q, 8'd0}) : num_q;
	assign div_den = cmd.div_avg ? ((seen_q == '0) ? DivDW'(256) : DivDW'(seen_q))
		: den_q[DivDW-1:0];

	ntc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		case (cmd.ln_sel)
			LnSelRs:   ln_x = AvgW'(rs_q);
			LnSelAvg:  ln_x = avg_q;
			LnSelDiff: ln_x = AvgW'(FullQ8) - avg_q;
			default:   ln_x = AvgW'(r0_q);
		endcase
	end

	ntc_ln #(.LnDepth(LnDepth)) u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ln_start),
		.x      (ln_x),
		.done   (ln_done),
		.res    (ln_res)
	);

	assign t0 = {{2{tc_q[TcW-1]}}, tc_q} + ZeroCenti;
	assign t0u = t0[15:0];
	assign beff = (beta_q == '0) ? BetaW'(1) : beta_q;
	assign den_pos = !den_q[41] && (den_q != '0);
	assign u = {1'b0, quo[21:0]} + RoundOfs;
	assign rr = $signed({1'b0, rp_s1[46:30]}) - TempBias;

	always_ff @(posedge clk) begin
		if (cmd.acc) chan_q <= chan;
		if (cmd.take_avg) begin
			avg_q <= quo[AvgW-1:0];
			zero_q <= (quo == '0);
			full_q <= (quo >= FullQ8);
			lacc_q <= '0;
		end else if (ln_done) begin
			if (cmd.ln_sel == LnSelRs || cmd.ln_sel == LnSelAvg)
				lacc_q <= lacc_q + $signed({3'b0, ln_res});
			else
				lacc_q <= lacc_q - $signed({3'b0, ln_res});
		end
		if (cmd.mul1) begin
			lt_s1 <= lacc_q * $signed({1'b0, t0u});
			bt_s1 <= 30'(beff) * 30'(t0u);
			bc_s1 <= 37'(beff) * 37'(BetaScale);
		end
		if (cmd.mul2) begin
			den_q <= lt_s1 + $signed({5'b0, bc_s1});
			numa_s2 <= DivNW'(bt_s1) * DivNW'(NumScale);
		end
		if (cmd.add) num_q <= numa_s2 + DivNW'(den_q[37:1]);
		if (cmd.recip) begin
			sathi_q <= (quo[DivNW-1:22] != '0);
			rp_s1 <= 47'(u) * 47'(RecipM);
		end
		if (cmd.fin) begin
			if (zero_q) begin
				res_temp_q <= '0;
				res_stat_q <= StAvgZero;
			end else if (full_q) begin
				res_temp_q <= '0;
				res_stat_q <= StAvgFull;
			end else if (!den_pos || sathi_q || rr > RMax) begin
				res_temp_q <= TempMax;
				res_stat_q <= StSat;
			end else if (rr < RMin) begin
				res_temp_q <= TempMin;
				res_stat_q <= StSat;
			end else begin
				res_temp_q <= rr[TempW-1:0];
				res_stat_q <= StOk;
			end
		end
		if (cmd.load_out) begin
			out_temp_q <= res_temp_q;
			out_chan_q <= chan_q;
			out_stat_q <= res_stat_q;
		end
	end

	always_comb begin
		stat.last = (seen_nx == '0) || (seen_nx >= need);
		stat.div_done = div_done;
		stat.avg_bad = (quo == '0) || (quo >= FullQ8);
		stat.ln_done = ln_done;
		stat.den_pos = den_pos;
		stat.out_busy = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_temp = out_temp_q;
	assign out_chan = out_chan_q;
	assign out_status = out_stat_q;

endmodule

`default_nettype wire

// ----- design/ntc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ntc_ctrl
// sequencer for accumulate, average, four logs, products, divide and output
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ntc_pkg::ntc_stat_t stat,
	output ntc_pkg::ntc_cmd_t       cmd
);
	import ntc_pkg::*;

	localparam logic [3:0] SIdle     = 4'd0;
	localparam logic [3:0] SDivaGo   = 4'd1;
	localparam logic [3:0] SDivaWait = 4'd2;
	localparam logic [3:0] SChk      = 4'd3;
	localparam logic [3:0] SLnGo     = 4'd4;
	localparam logic [3:0] SLnWait   = 4'd5;
	localparam logic [3:0] SMul1     = 4'd6;
	localparam logic [3:0] SMul2     = 4'd7;
	localparam logic [3:0] SAdd      = 4'd8;
	localparam logic [3:0] SDivqGo   = 4'd9;
	localparam logic [3:0] SDivqWait = 4'd10;
	localparam logic [3:0] SRec      = 4'd11;
	localparam logic [3:0] SFin      = 4'd12;
	localparam logic [3:0] SOut      = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] sel_q;

	always_comb begin
		cmd = '0;
		cmd.ln_sel = sel_q;
		state_d = state_q;
		in_ready = (state_q == SIdle);
		case (state_q)
			SIdle: begin
				if (in_valid) begin
					cmd.acc = 1'b1;
					if (stat.last) state_d = SDivaGo;
				end
			end
			SDivaGo: begin
				cmd.div_avg = 1'b1;
				state_d = SDivaWait;
			end
			SDivaWait: begin
				if (stat.div_done) state_d = SChk;
			end
			SChk: begin
				cmd.take_avg = 1'b1;
				state_d = stat.avg_bad ? SFin : SLnGo;
			end
			SLnGo: begin
				cmd.ln_start = 1'b1;
				state_d = SLnWait;
			end
			SLnWait: begin
				if (stat.ln_done) state_d = (sel_q == LnSelR0) ? SMul1 : SLnGo;
			end
			SMul1: begin
				cmd.mul1 = 1'b1;
				state_d = SMul2;
			end
			SMul2: begin
				cmd.mul2 = 1'b1;
				state_d = SAdd;
			end
			SAdd: begin
				cmd.add = 1'b1;
				state_d = stat.den_pos ? SDivqGo : SFin;
			end
			SDivqGo: begin
				cmd.div_temp = 1'b1;
				state_d = SDivqWait;
			end
			SDivqWait: begin
				if (stat.div_done) state_d = SRec;
			end
			SRec: begin
				cmd.recip = 1'b1;
				state_d = SFin;
			end
			SFin: begin
				cmd.fin = 1'b1;
				state_d = SOut;
			end
			SOut: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = SIdle;
				end
			end
			default: state_d = SIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle;
			sel_q <= LnSelRs;
		end else begin
			state_q <= state_d;
			if (state_q == SChk) sel_q <= LnSelRs;
			else if (state_q == SLnWait && stat.ln_done) sel_q <= sel_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// ----- design/ntc_thermistor_temperature.sv -----
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature
// adc burst averaging and beta-equation thermistor temperature
// ----------------------------------------------------------------------------
// usage:
//   samples enter on the s_axis channel, one beat per cycle while tready is
//   high; tuser carries the channel tag. every sample_count beats form a burst.
//   the burst's last beat starts the calculation and the input holds tready low
//   until the result is staged in the output register.
//   from the last sample to m_axis_tvalid, the 59-bit restoring divider runs
//   twice (average, then temperature) and the log unit runs four times, each
//   time with its normalize shifts. a zero or full-scale average skips the
//   logs and the second divide; a non-positive denominator skips the second
//   divide. throughput is one result per burst of n samples; no new samples
//   are taken while a result is being calculated.
//   the output register lets new samples be accepted while a result waits;
//   if the receiver stalls, the next result waits in the sequencer, and input
//   stays blocked, until the output register is taken.
//   reset (arst_n low) clears the burst accumulator, empties the output and restores all
//   configuration registers to their defaults. configuration is written through cfg_we /
//   cfg_index / cfg_data; the user must write it only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_thermistor_temperature #(
	parameter int AdcFullScale = ntc_pkg::DefAdcFullScale,
	parameter int LnTableDepth = ntc_pkg::DefLnTableDepth
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [15:0]                  s_axis_tdata,  // [9:0] sample
	input  wire logic [1:0]                   s_axis_tuser,  // [1:0] channel
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [15:0]                       m_axis_tdata,  // [14:0] temperature
	output logic [3:0]                        m_axis_tuser,  // [1:0] channel_out, [3:2] status
	input  wire logic                         cfg_we,
	input  wire logic [ntc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [ntc_pkg::CfgDataW-1:0] cfg_data
);
	import ntc_pkg::*;

	ntc_cmd_t         cmd;
	ntc_stat_t        stat;
	logic [TempW-1:0] temperature;
	logic [ChanW-1:0] channel_out;
	logic [StatW-1:0] status;

	ntc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ntc_dp #(
		.AdcFullScale (AdcFullScale),
		.LnDepth      (LnTableDepth)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample     (s_axis_tdata[SampleW-1:0]),
		.chan       (s_axis_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_temp   (temperature),
		.out_chan   (channel_out),
		.out_status (status)
	);

	assign m_axis_tdata = {1'b0, temperature};
	assign m_axis_tuser = {status, channel_out};

endmodule

`default_nettype wire

// ----- design/ntc_checker.sv -----
// ----------------------------------------------------------------------------
// ntc_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ntc_thermistor_temperature_assert.svh"

module ntc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [3:0]  m_axis_tuser
);
	import ntc_pkg::*;

	// a stalled beat holds
	`NTC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

	// bad average gives a zero temperature
	`NTC_ASSERT_IMPLY(a_bad_avg_zero, clk, arst_n, m_axis_tvalid && (m_axis_tuser[3:2] == StAvgZero || m_axis_tuser[3:2] == StAvgFull), m_axis_tdata == 16'd0, "bad average with nonzero temperature")

	// saturation sits on a limit
	`NTC_ASSERT_IMPLY(a_sat_limit, clk, arst_n, m_axis_tvalid && m_axis_tuser[3:2] == StSat, m_axis_tdata[14:0] == TempMax || m_axis_tdata[14:0] == TempMin, "saturated result off the limits")

	// pad bit stays clear
	`NTC_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_axis_tvalid, !m_axis_tdata[15], "tdata pad bit set")

endmodule

bind ntc_thermistor_temperature ntc_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// ntc thermistor temperature testbench
// drives adc sample bursts under several register settings, predicts each
// temperature beat in fixed point and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
	logic [14:0] temp;
	logic [1:0]  chan;
	logic [1:0]  status;
} temp_beat_t;

class temp_scoreboard;
	localparam int Depth = ntc_pkg::DefLnTableDepth;
	localparam int FullScale = ntc_pkg::DefAdcFullScale;

	longint unsigned ln_frac[0:Depth];
	bit [7:0]  burst_len;
	bit [19:0] rs_ohm;
	bit [19:0] r0_ohm;
	bit [13:0] beta;
	bit [14:0] t0_centi;
	bit [17:0] sum;
	bit [7:0]  seen;
	temp_beat_t pending[$];
	int errors;

	function new();
		longint unsigned z, z2, term, s;
		for (int k = 0; k <= Depth; k++) begin
			z = (longint'(k) << 32) / (2 * Depth + k);
			z2 = (z * z) >> 32;
			term = z;
			s = 0;
			for (int n = 0; n < 25; n++) begin
				s += term / (2 * n + 1);
				term = (term * z2) >> 32;
			end
			ln_frac[k] = (2 * s + 32768) >> 16;
		end
		burst_len = 5;
		rs_ohm = 10000;
		r0_ohm = 10000;
		beta = 3950;
		t0_centi = 2500;
		sum = 0;
		seen = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [19:0] val);
		case (idx)
			ntc_pkg::RegSampleCount: burst_len = val[7:0];
			ntc_pkg::RegSeriesRes:   rs_ohm = val;
			ntc_pkg::RegNominalRes:  r0_ohm = val;
			ntc_pkg::RegBeta:        beta = val[13:0];
			ntc_pkg::RegNominalTemp: t0_centi = val[14:0];
			default: ;
		endcase
	endfunction

	// log2 exponent times ln2 plus interpolated mantissa table, q16
	function longint ln_q16(longint unsigned x);
		int e;
		longint unsigned f, frac, pos, idx, rem, lo, hi;
		if (x == 0)
			x = 1;
		e = 0;
		while (e < 40 && (x >> (e + 1)) != 0)
			e++;
		f = x - (64'd1 << e);
		frac = (f << 32) >> e;
		pos = frac * Depth;
		idx = pos >> 32;
		rem = pos & 64'hFFFF_FFFF;
		if (idx >= Depth) begin
			idx = Depth - 1;
			rem = 64'hFFFF_FFFF;
		end
		lo = ln_frac[idx];
		hi = ln_frac[idx + 1];
		return longint'(e) * 45426 + longint'(lo + (((hi - lo) * rem) >> 32));
	endfunction

	function void note_sample(logic [9:0] smp, logic [1:0] ch);
		int need;
		longint unsigned n, avg, full;
		longint l, b, t0, den, num, q, x, r;
		temp_beat_t exp_beat;
		need = (burst_len == 0) ? 1 : burst_len;
		sum = sum + smp;
		seen = seen + 1;
		if (seen != 0 && seen < need)
			return;
		n = (seen == 0) ? 256 : seen;
		avg = (longint'(sum) << 8) / n;
		full = longint'(FullScale) << 8;
		sum = 0;
		seen = 0;
		r = 0;
		exp_beat.status = ntc_pkg::StOk;
		if (avg == 0) begin
			exp_beat.status = ntc_pkg::StAvgZero;
		end else if (avg >= full) begin
			exp_beat.status = ntc_pkg::StAvgFull;
		end else begin
			l = ln_q16(rs_ohm) + ln_q16(avg) - ln_q16(full - avg) - ln_q16(r0_ohm);
			b = (beta == 0) ? 1 : beta;
			t0 = longint'($signed(t0_centi)) + 27315;
			den = l * t0 + 100 * 65536 * b;
			if (den <= 0) begin
				r = 16383;
				exp_beat.status = ntc_pkg::StSat;
			end else begin
				num = 6400 * 65536 * b * t0;
				q = (num + den / 2) / den;
				x = q - 1748160 + 50;
				r = (x >= 0) ? x / 100 : -((-x + 99) / 100);
				if (r > 16383) begin
					r = 16383;
					exp_beat.status = ntc_pkg::StSat;
				end
				if (r < -16384) begin
					r = -16384;
					exp_beat.status = ntc_pkg::StSat;
				end
			end
		end
		exp_beat.temp = r[14:0];
		exp_beat.chan = ch;
		pending.push_back(exp_beat);
	endfunction

	function void check(logic [15:0] data, logic [3:0] user);
		temp_beat_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result beat: data %h user %h", data, user);
			return;
		end
		e = pending.pop_front();
		if (data[14:0] !== e.temp || user[1:0] !== e.chan || user[3:2] !== e.status) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: temp %0d/%0d chan %0d/%0d status %0d/%0d (exp/act)",
					$signed(e.temp), $signed(data[14:0]), e.chan, user[1:0],
					e.status, user[3:2]);
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 5000;
	localparam int DrainCycles = 400;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [9:0] sample
	logic [1:0]  s_axis_tuser;   // [1:0] channel
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [14:0] temperature
	logic [3:0]  m_axis_tuser;   // [1:0] channel_out, [3:2] status
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;

	temp_scoreboard sb = new();
	bit quiet;
	int stall_left;
	int idle_cycles;

	ntc_thermistor_temperature u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(7) == 0) begin
			stall_left = $urandom_range(4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_sample(logic [9:0] smp, logic [1:0] ch);
		if (!quiet && $urandom_range(5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, smp};
		s_axis_tuser <= ch;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_sample(smp, ch);
	endtask

	// drains the pipeline, then writes registers while the block is idle
	task automatic write_regs(logic [7:0] cnt, logic [19:0] rs, logic [19:0] r0,
			logic [13:0] b, logic [14:0] t0);
		logic [19:0] vals[5];
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		vals = '{20'(cnt), rs, r0, 20'(b), 20'(t0)};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= (i == 5) ? 3'($urandom_range(5, 7)) : 3'(i);
			cfg_data <= (i == 5) ? 20'($urandom) : vals[i];
			if (i < 5)
				sb.set_reg(3'(i), vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_samples(int count);
		int need, style, left;
		logic [9:0] smp;
		left = 0;
		style = 0;
		for (int i = 0; i < count; i++) begin
			if (left == 0) begin
				need = (sb.burst_len == 0) ? 1 : sb.burst_len;
				left = need;
				style = $urandom_range(9);
			end
			case (style)
				0: smp = 10'd0;
				1: smp = 10'd1023;
				2: smp = 10'($urandom_range(3));
				3: smp = 10'($urandom_range(1020, 1023));
				default: smp = 10'($urandom);
			endcase
			send_sample(smp, 2'($urandom));
			left--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 0;
		stall_left = 0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: zero, full scale, midscale and mixed bursts, then one-count bursts
		repeat (5) send_sample(10'd0, 2'd0);
		repeat (5) send_sample(10'd1023, 2'd3);
		repeat (5) send_sample(10'd512, 2'd1);
		for (int i = 0; i < 5; i++)
			send_sample((i % 2) ? 10'd1023 : 10'd1, 2'(i));
		write_regs(8'd1, 20'd10000, 20'd10000, 14'd3950, 15'd2500);
		send_sample(10'd1, 2'd2);
		send_sample(10'd1022, 2'd1);
		send_sample(10'd341, 2'd3);
		random_samples(150);

		// zero count means one, hot extreme
		write_regs(8'd0, 20'd1, 20'd1000000, 14'd1000, 15'(-4000));
		random_samples(60);

		write_regs(8'd255, 20'd1000000, 20'd1, 14'd10000, 15'd15000);
		random_samples(255);

		// zero resistances and beta act as one, coldest nominal temperature
		write_regs(8'd3, 20'hFFFFF, 20'd0, 14'h3FFF, 15'h4000);
		random_samples(120);
		write_regs(8'd2, 20'd0, 20'hFFFFF, 14'd0, 15'h3FFF);
		random_samples(60);

		// count lowered below what the open burst has already seen
		write_regs(8'd7, 20'd4700, 20'd10000, 14'd3435, 15'd2500);
		random_samples(4);
		write_regs(8'd2, 20'd4700, 20'd10000, 14'd3435, 15'd2500);
		random_samples(100);

		write_regs(8'd4, 20'd10000, 20'd10000, 14'd3950, 15'd2500);
		random_samples(100);
		quiet = 1;
		random_samples(100);

		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/ntc_pkg.sv
design/ntc_div.sv
design/ntc_ln.sv
design/ntc_dp.sv
design/ntc_ctrl.sv
design/ntc_thermistor_temperature.sv
design/ntc_checker.sv
bench/testbench.sv
